// ===== rtl/bss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, codes and widths for the bounded stack with search.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int BSS_DEPTH_DEF = 8;
    localparam int MODE_W        = 2;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 3;
    localparam int POS_W         = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_SEARCH = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_UNDERFLOW= 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FOUND    = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_OUT,
        S_DUMP,
        S_SCAN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    latch;
        logic    push_wr;
        logic    rd_top;
        logic    cnt_dec;
        logic    rd_bot;
        logic    rd_down;
        logic    rd_up;
        logic    emit;
        t_status emit_status;
        logic    emit_data;
        logic    emit_pos;
        logic    emit_last;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  full;
        logic  match;
        logic  ptr_zero;
        logic  ptr_top;
        logic  out_free;
    } t_ctrl_stat;

endpackage
`default_nettype wire

// ===== rtl/bss_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_in_if
// Request channel: operation code and operand with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bss_in_if import bss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output mode, output operand_value, input ready);
    modport sink   (input valid, input mode, input operand_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/bss_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_out_if
// Result channel: status, data, position and last mark with valid/ready.
// ----------------------------------------------------------------------------
interface bss_out_if import bss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_value;
    logic [POS_W-1:0]         position;
    logic                     last;

    modport source (output valid, output status, output data_value, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input data_value, input position,
                    input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/bounded_stack_with_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// results: push and refused ops answer from the execute state once the request is taken,
//   pop after a top read, dump one result per entry, search after up to fill count reads
// throughput: one request at a time; dump and search walk the entry memory through its
//   single registered read port, one entry per cycle; dump pauses on a held result
// reset: fill count and sequencer clear, stack empty; entry memory is not cleared
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// Fixed-depth stack of signed words with push, pop, dump and key search.
// ----------------------------------------------------------------------------
module bounded_stack_with_search import bss_pkg::*; #(
    parameter int DEPTH = BSS_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bss_in_if.sink    i_req,
    bss_out_if.source o_rsp
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    assign i_req.ready = cmd.in_ready;

    bss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_req.mode),
        .i_operand   (i_req.operand_value),
        .i_out_ready (o_rsp.ready),
        .o_stat      (stat),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_data      (o_rsp.data_value),
        .o_position  (o_rsp.position),
        .o_last      (o_rsp.last)
    );

endmodule
`default_nettype wire

// ===== rtl/bss_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_ctrl
// Sequencer for push, pop, dump walk and bottom-up search.
// ----------------------------------------------------------------------------
module bss_ctrl import bss_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_ctrl_stat i_stat,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (i_stat.mode)
                    MODE_PUSH: begin
                        if (i_stat.out_free) n_state = S_IDLE;
                    end
                    MODE_POP: begin
                        if (!i_stat.empty)        n_state = S_POP_OUT;
                        else if (i_stat.out_free) n_state = S_IDLE;
                    end
                    MODE_DUMP: begin
                        if (!i_stat.empty)        n_state = S_DUMP;
                        else if (i_stat.out_free) n_state = S_IDLE;
                    end
                    MODE_SEARCH: begin
                        if (!i_stat.empty)        n_state = S_SCAN;
                        else if (i_stat.out_free) n_state = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POP_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_DUMP: begin
                if (i_stat.out_free && i_stat.ptr_zero) n_state = S_IDLE;
            end
            S_SCAN: begin
                if ((i_stat.match || i_stat.ptr_top) && i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.emit_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.latch    = i_valid;
            end
            S_EXEC: begin
                case (i_stat.mode)
                    MODE_PUSH: begin
                        o_cmd.emit        = i_stat.out_free;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.push_wr     = i_stat.out_free && !i_stat.full;
                        o_cmd.emit_status = i_stat.full ? ST_OVERFLOW : ST_OK;
                    end
                    MODE_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.emit        = i_stat.out_free;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_UNDERFLOW;
                        end else begin
                            o_cmd.rd_top  = 1'b1;
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end
                    MODE_DUMP: begin
                        if (i_stat.empty) begin
                            o_cmd.emit        = i_stat.out_free;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_EMPTY;
                        end else begin
                            o_cmd.rd_top = 1'b1;
                        end
                    end
                    MODE_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.emit        = i_stat.out_free;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_NOTFOUND;
                        end else begin
                            o_cmd.rd_bot = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_POP_OUT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_data = 1'b1;
                o_cmd.emit_last = 1'b1;
            end
            S_DUMP: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_data = 1'b1;
                o_cmd.emit_last = i_stat.ptr_zero;
                o_cmd.rd_down   = i_stat.out_free && !i_stat.ptr_zero;
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.emit        = i_stat.out_free;
                    o_cmd.emit_pos    = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_FOUND;
                end else if (i_stat.ptr_top) begin
                    o_cmd.emit        = i_stat.out_free;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_NOTFOUND;
                end else begin
                    o_cmd.rd_up = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/bss_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_dp
// Entry memory, fill count, walk pointer, key compare and result register.
// ----------------------------------------------------------------------------
module bss_dp import bss_pkg::*; #(
    parameter int DEPTH = BSS_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctrl_cmd                i_cmd,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic signed [DATA_W-1:0] i_operand,
    input  wire logic                     i_out_ready,
    output t_ctrl_stat                    o_stat,
    output logic                          o_out_valid,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [DATA_W-1:0]      o_data,
    output logic [POS_W-1:0]              o_position,
    output logic                          o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_key;
    t_mode             r_mode;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     n_ptr;
    logic              rd_en;
    logic [CW-1:0]     ptr_ext;
    logic [CW-1:0]     pos_diff;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_data;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_out_last;

    assign rd_en    = i_cmd.rd_top || i_cmd.rd_bot || i_cmd.rd_down || i_cmd.rd_up;
    assign ptr_ext  = CW'(r_ptr);
    assign pos_diff = r_count - ptr_ext;

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.rd_top)       n_ptr = AW'(r_count - 1'b1);
        else if (i_cmd.rd_bot)  n_ptr = '0;
        else if (i_cmd.rd_down) n_ptr = r_ptr - 1'b1;
        else if (i_cmd.rd_up)   n_ptr = r_ptr + 1'b1;
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push_wr)      n_count = r_count + 1'b1;
        else if (i_cmd.cnt_dec) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) r_mem[AW'(r_count)] <= r_key;
    end

    // read data holds while the walk waits on the result register
    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_data   <= i_cmd.emit_data ? r_rd_data : '0;
            r_out_pos    <= i_cmd.emit_pos ? POS_W'(pos_diff) : '0;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.match    = (r_rd_data == r_key);
    assign o_stat.ptr_zero = (r_ptr == '0);
    assign o_stat.ptr_top  = ((ptr_ext + 1'b1) == r_count);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data      = r_out_data;
    assign o_position  = r_out_pos;
    assign o_last      = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |-> (r_count != CW'(DEPTH)))
        else $error("write into a full stack");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("push did not grow the stack");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0))
        else $error("pop from an empty stack");

endmodule
`default_nettype wire
